/* src/rgb_to_hsv_converter_unit_assert.svh */
// assertion macros shared by the rgb to hsv checker
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RHSV_ASSERT_IMPL(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("rhsv assertion failed");

// next-cycle implication, checked outside reset
`define RHSV_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("rhsv assertion failed");

`endif

/* src/rhsv_pkg.sv */
// shared types, constants and tables of the rgb to hsv converter
package rhsv_pkg;

    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 13;
    localparam int PCT_W   = 15;

    localparam int HUE_TURN   = 5760;
    localparam int HUE_SECTOR = 1920;
    localparam int HUE_SCALE  = 960;
    localparam int PCT_SCALE  = 25600;
    localparam int CHAN_FULL  = 255;

    // divider geometry, shared by the hue and saturation lanes
    localparam int DIV_NUM_W  = 24;
    localparam int DIV_DEN_W  = CHAN_W + 1;
    localparam int DIV_Q_W    = 15;
    localparam int DIV_STAGES = DIV_Q_W;

    // pipeline: two front stages, the divider stages, one output stage
    localparam int DIV_FIRST   = 2;
    localparam int PIPE_STAGES = DIV_FIRST + DIV_STAGES + 1;
    localparam int OUT_STAGE   = PIPE_STAGES - 1;

    typedef logic [1:0] sector_t;

    localparam sector_t SECT_RED   = 2'd0;
    localparam sector_t SECT_GREEN = 2'd1;
    localparam sector_t SECT_BLUE  = 2'd2;

    localparam int LUT_DEPTH = 1 << CHAN_W;

    typedef logic [LUT_DEPTH-1:0][PCT_W-1:0] val_lut_t;

    // brightness per max channel, rounded to nearest
    function automatic val_lut_t make_val_lut();
        val_lut_t lut;
        int       v;
        for (int m = 0; m < LUT_DEPTH; m++)
        begin
            v = (2 * m * PCT_SCALE + CHAN_FULL) / (2 * CHAN_FULL);
            lut[m] = PCT_W'(v);
        end
        return lut;
    endfunction

    localparam val_lut_t VAL_LUT = make_val_lut();

endpackage

/* src/rhsv_div.sv */
// pipelined restoring divider, one quotient bit per stage
module rhsv_div (
    input  logic                                clk,
    input  logic [rhsv_pkg::DIV_STAGES-1:0]     en,
    input  logic [rhsv_pkg::DIV_NUM_W-1:0]      num,
    input  logic [rhsv_pkg::DIV_DEN_W-1:0]      den,
    output logic [rhsv_pkg::DIV_Q_W-1:0]        quo
);

    logic [rhsv_pkg::DIV_NUM_W-1:0] p_reg [rhsv_pkg::DIV_STAGES];
    logic [rhsv_pkg::DIV_DEN_W-1:0] d_reg [rhsv_pkg::DIV_STAGES];
    logic [rhsv_pkg::DIV_Q_W-1:0]   q_reg [rhsv_pkg::DIV_STAGES];

    for (genvar i = 0; i < rhsv_pkg::DIV_STAGES; i++)
    begin : g_stage
        localparam int BIT = rhsv_pkg::DIV_Q_W - 1 - i;

        logic [rhsv_pkg::DIV_NUM_W-1:0] p_in;
        logic [rhsv_pkg::DIV_DEN_W-1:0] d_in;
        logic [rhsv_pkg::DIV_Q_W-1:0]   q_in;
        logic [rhsv_pkg::DIV_NUM_W-1:0] trial;
        logic [rhsv_pkg::DIV_NUM_W-1:0] p_next;
        logic [rhsv_pkg::DIV_Q_W-1:0]   q_next;

        if (i == 0)
        begin : g_first
            assign p_in = num;
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign p_in = p_reg[i-1];
            assign d_in = d_reg[i-1];
            assign q_in = q_reg[i-1];
        end

        // shifted divisor for this quotient bit
        assign trial = rhsv_pkg::DIV_NUM_W'(d_in) << BIT;

        always_comb
        begin
            p_next = p_in;
            q_next = q_in;
            if (p_in >= trial)
            begin
                p_next      = p_in - trial;
                q_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                p_reg[i] <= p_next;
                d_reg[i] <= d_in;
                q_reg[i] <= q_next;
            end
        end
    end

    assign quo = q_reg[rhsv_pkg::DIV_STAGES-1];

endmodule

/* src/rgb_to_hsv_converter_unit.sv */
// top level of the rgb to hsv converter: one 8-bit rgb pixel in, hue/saturation/value out
//
// Converts a stream of 8-bit RGB pixels to HSV at one pixel per clock, unless a full
// pipeline waits on hsv_ready. Hue comes out in 1/16 degree (0..5759), saturation and
// brightness in 1/256 percent (0..25600), all rounded to nearest; grey pixels give hue
// and saturation of zero, and ties for the largest channel go to red, then green, then
// blue. One stage finds max, min and the hue sector, one stage builds the dividends,
// 15 stages of restoring division produce one quotient bit each (hue and saturation
// run in two parallel lanes), and an output register holds the result. Both channels
// use valid/ready; every stage advances on its own, so empty slots close up and
// pixel_ready stays high while the pipeline has a free slot, even while a finished
// result waits for hsv_ready. Reset clears only the valid bits.
module rgb_to_hsv_converter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  logic [rhsv_pkg::CHAN_W-1:0] red,
    input  logic [rhsv_pkg::CHAN_W-1:0] green,
    input  logic [rhsv_pkg::CHAN_W-1:0] blue,
    output logic                        hsv_valid,
    input  logic                        hsv_ready,
    output logic [rhsv_pkg::HUE_W-1:0]  hue,
    output logic [rhsv_pkg::PCT_W-1:0]  saturation,
    output logic [rhsv_pkg::PCT_W-1:0]  brightness
);

    localparam int N = rhsv_pkg::DIV_NUM_W;
    localparam int S = rhsv_pkg::DIV_STAGES;

    // per-stage valid bits and load enables
    logic [rhsv_pkg::PIPE_STAGES-1:0] valid_reg;
    logic [rhsv_pkg::PIPE_STAGES-1:0] valid_next;
    logic [rhsv_pkg::PIPE_STAGES-1:0] stage_en;

    // a stage may load when some stage at or after it is empty, or the output drains
    always_comb
    begin
        for (int k = 0; k < rhsv_pkg::PIPE_STAGES; k++)
        begin
            stage_en[k] = hsv_ready || (|(~valid_reg >> k));
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int k = 0; k < rhsv_pkg::PIPE_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = (k == 0) ? pixel_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pixel_ready = stage_en[0];
    assign hsv_valid   = valid_reg[rhsv_pkg::OUT_STAGE];

    // stage 1: max, min, sector and the signed channel difference
    logic [rhsv_pkg::CHAN_W-1:0] s1_max_next;
    logic [rhsv_pkg::CHAN_W-1:0] s1_min;
    logic [rhsv_pkg::CHAN_W-1:0] s1_delta_next;
    rhsv_pkg::sector_t           s1_sector_next;
    logic [rhsv_pkg::CHAN_W-1:0] s1_diff_next;
    logic                        s1_neg_next;
    logic [rhsv_pkg::CHAN_W-1:0] pair_a;
    logic [rhsv_pkg::CHAN_W-1:0] pair_c;

    logic [rhsv_pkg::CHAN_W-1:0] s1_max_reg;
    logic [rhsv_pkg::CHAN_W-1:0] s1_delta_reg;
    rhsv_pkg::sector_t           s1_sector_reg;
    logic [rhsv_pkg::CHAN_W-1:0] s1_diff_reg;
    logic                        s1_neg_reg;

    always_comb
    begin
        s1_max_next = red;
        if (green > s1_max_next)
        begin
            s1_max_next = green;
        end
        if (blue > s1_max_next)
        begin
            s1_max_next = blue;
        end
        s1_min = red;
        if (green < s1_min)
        begin
            s1_min = green;
        end
        if (blue < s1_min)
        begin
            s1_min = blue;
        end
        s1_delta_next = s1_max_next - s1_min;

        // ties go to red, then green
        if (s1_max_next == red)
        begin
            s1_sector_next = rhsv_pkg::SECT_RED;
        end
        else if (s1_max_next == green)
        begin
            s1_sector_next = rhsv_pkg::SECT_GREEN;
        end
        else
        begin
            s1_sector_next = rhsv_pkg::SECT_BLUE;
        end

        case (s1_sector_next)
            rhsv_pkg::SECT_RED:
            begin
                pair_a = green;
                pair_c = blue;
            end
            rhsv_pkg::SECT_GREEN:
            begin
                pair_a = blue;
                pair_c = red;
            end
            default:
            begin
                pair_a = red;
                pair_c = green;
            end
        endcase

        s1_neg_next  = pair_a < pair_c;
        s1_diff_next = s1_neg_next ? (pair_c - pair_a) : (pair_a - pair_c);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_max_reg    <= s1_max_next;
            s1_delta_reg  <= s1_delta_next;
            s1_sector_reg <= s1_sector_next;
            s1_diff_reg   <= s1_diff_next;
            s1_neg_reg    <= s1_neg_next;
        end
    end

    // stage 2: rounding dividends and doubled divisors, brightness from table
    logic [N-1:0]                   delta_w;
    logic [N-1:0]                   scaled_diff;
    logic [N-1:0]                   hue_base;
    logic [N-1:0]                   hue_num;
    logic [N-1:0]                   s2_hue_num_next;
    logic [N-1:0]                   s2_sat_num_next;

    logic [N-1:0]                   s2_hue_num_reg;
    logic [rhsv_pkg::DIV_DEN_W-1:0] s2_hue_den_reg;
    logic [N-1:0]                   s2_sat_num_reg;
    logic [rhsv_pkg::DIV_DEN_W-1:0] s2_sat_den_reg;
    logic [rhsv_pkg::PCT_W-1:0]     s2_val_reg;
    logic                           s2_grey_reg;

    always_comb
    begin
        delta_w     = N'(s1_delta_reg);
        scaled_diff = N'(rhsv_pkg::HUE_SCALE) * N'(s1_diff_reg);
        case (s1_sector_reg)
            rhsv_pkg::SECT_RED:
            begin
                // negative red hue wraps by a full turn
                hue_base = s1_neg_reg ? N'(rhsv_pkg::HUE_TURN) * delta_w : '0;
            end
            rhsv_pkg::SECT_GREEN:
            begin
                hue_base = N'(rhsv_pkg::HUE_SECTOR) * delta_w;
            end
            default:
            begin
                hue_base = N'(2 * rhsv_pkg::HUE_SECTOR) * delta_w;
            end
        endcase
        hue_num         = s1_neg_reg ? (hue_base - scaled_diff) : (hue_base + scaled_diff);
        s2_hue_num_next = (hue_num << 1) + delta_w;
        s2_sat_num_next = N'(2 * rhsv_pkg::PCT_SCALE) * delta_w + N'(s1_max_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_hue_num_reg <= s2_hue_num_next;
            s2_hue_den_reg <= {s1_delta_reg, 1'b0};
            s2_sat_num_reg <= s2_sat_num_next;
            s2_sat_den_reg <= {s1_max_reg, 1'b0};
            s2_val_reg     <= rhsv_pkg::VAL_LUT[s1_max_reg];
            s2_grey_reg    <= (s1_delta_reg == '0);
        end
    end

    // divider lanes
    logic [rhsv_pkg::DIV_Q_W-1:0] hue_quo;
    logic [rhsv_pkg::DIV_Q_W-1:0] sat_quo;

    rhsv_div u_hue_div (
        .clk (clk),
        .en  (stage_en[rhsv_pkg::DIV_FIRST +: S]),
        .num (s2_hue_num_reg),
        .den (s2_hue_den_reg),
        .quo (hue_quo)
    );

    rhsv_div u_sat_div (
        .clk (clk),
        .en  (stage_en[rhsv_pkg::DIV_FIRST +: S]),
        .num (s2_sat_num_reg),
        .den (s2_sat_den_reg),
        .quo (sat_quo)
    );

    // brightness and grey flag ride alongside the divider
    logic [rhsv_pkg::PCT_W-1:0] side_val_reg  [S];
    logic                       side_grey_reg [S];

    always_ff @(posedge clk)
    begin
        if (stage_en[rhsv_pkg::DIV_FIRST])
        begin
            side_val_reg[0]  <= s2_val_reg;
            side_grey_reg[0] <= s2_grey_reg;
        end
        for (int i = 1; i < S; i++)
        begin
            if (stage_en[rhsv_pkg::DIV_FIRST + i])
            begin
                side_val_reg[i]  <= side_val_reg[i-1];
                side_grey_reg[i] <= side_grey_reg[i-1];
            end
        end
    end

    // output stage: full-turn wrap and grey override
    logic [rhsv_pkg::HUE_W-1:0] hue_next;
    logic [rhsv_pkg::PCT_W-1:0] sat_next;
    logic [rhsv_pkg::HUE_W-1:0] hue_reg;
    logic [rhsv_pkg::PCT_W-1:0] sat_reg;
    logic [rhsv_pkg::PCT_W-1:0] val_reg;

    always_comb
    begin
        if (side_grey_reg[S-1] || hue_quo == rhsv_pkg::DIV_Q_W'(rhsv_pkg::HUE_TURN))
        begin
            hue_next = '0;
        end
        else
        begin
            hue_next = hue_quo[rhsv_pkg::HUE_W-1:0];
        end
        sat_next = side_grey_reg[S-1] ? '0 : sat_quo[rhsv_pkg::PCT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[rhsv_pkg::OUT_STAGE])
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= side_val_reg[S-1];
        end
    end

    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = val_reg;

endmodule

/* src/rhsv_checker.sv */
// port-level checker for the rgb to hsv converter, bound to the top level
`include "rgb_to_hsv_converter_unit_assert.svh"

module rhsv_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pixel_valid,
    input logic                        pixel_ready,
    input logic [rhsv_pkg::CHAN_W-1:0] red,
    input logic [rhsv_pkg::CHAN_W-1:0] green,
    input logic [rhsv_pkg::CHAN_W-1:0] blue,
    input logic                        hsv_valid,
    input logic                        hsv_ready,
    input logic [rhsv_pkg::HUE_W-1:0]  hue,
    input logic [rhsv_pkg::PCT_W-1:0]  saturation,
    input logic [rhsv_pkg::PCT_W-1:0]  brightness
);

    // results stay within their ranges
    `RHSV_ASSERT_IMPL(a_out_range, clk, rst_n, hsv_valid, (hue < rhsv_pkg::HUE_W'(rhsv_pkg::HUE_TURN)) && (saturation <= rhsv_pkg::PCT_W'(rhsv_pkg::PCT_SCALE)) && (brightness <= rhsv_pkg::PCT_W'(rhsv_pkg::PCT_SCALE)))

    // zero saturation only for grey pixels, which carry zero hue
    `RHSV_ASSERT_IMPL(a_grey_hue, clk, rst_n, hsv_valid && (saturation == '0), hue == '0)

    // a draining output never blocks new requests
    `RHSV_ASSERT_IMPL(a_ready_flow, clk, rst_n, hsv_ready, pixel_ready)

    // a stalled result holds
    `RHSV_ASSERT_NEXT(a_out_hold, clk, rst_n, hsv_valid && !hsv_ready, hsv_valid && $stable(hue) && $stable(saturation) && $stable(brightness))

endmodule

bind rgb_to_hsv_converter_unit rhsv_checker u_rhsv_checker (.*);
